FILE: rtl/core/acfu_pkg.sv
// ============================================================================
// Air-conditioner command frame updater: shared types and constants
// Field widths, the frame reset pattern and the update operation that
// travels from the command decoder to the frame register.
// ============================================================================
`default_nettype none

package acfu_pkg;

    // Payload widths of the stream channels.
    localparam int CHAR_BITS    = 8;
    localparam int IN_DATA_BITS = 40;
    localparam int OUT_BITS     = 35;
    localparam int OUT_DATA_BITS = 40;

    // Every command touches only the low 26 bits of the frame.
    localparam int UPD_BITS = 26;

    // Depth of the queue between decoder and frame register.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Frame after reset: bits 9, 11, 28, 30 and 33 set.
    localparam logic [OUT_BITS-1:0] FRAME_RESET =
        (35'd1 << 9) | (35'd1 << 11) | (35'd1 << 28) | (35'd1 << 30) | (35'd1 << 33);

    // Bits to replace and the values to put in them.
    typedef struct packed {
        logic [UPD_BITS-1:0] mask;
        logic [UPD_BITS-1:0] value;
    } acfu_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/acfu_front.sv
// ============================================================================
// Air-conditioner command frame updater: command decoder
// Turns one ASCII command into a mask and value pair for the frame.
// Commands shorter than two bytes are absorbed without an operation.
// ============================================================================
`default_nettype none

module acfu_front
(
    input  wire logic [acfu_pkg::CHAR_BITS-1:0] first_char,
    input  wire logic [acfu_pkg::CHAR_BITS-1:0] second_char,
    input  wire logic [acfu_pkg::CHAR_BITS-1:0] third_char,
    input  wire logic [acfu_pkg::CHAR_BITS-1:0] fourth_char,
    input  wire logic [acfu_pkg::CHAR_BITS-1:0] command_length,
    output acfu_pkg::acfu_op_t                   op,
    output logic                                 emits
);
    import acfu_pkg::*;

    localparam logic [7:0] CHAR_0 = "0";
    localparam logic [7:0] CHAR_1 = "1";
    localparam logic [7:0] CHAR_2 = "2";
    localparam logic [7:0] CHAR_3 = "3";
    localparam logic [7:0] CHAR_4 = "4";
    localparam logic [7:0] CHAR_5 = "5";
    localparam logic [7:0] CHAR_9 = "9";
    localparam logic [7:0] CHAR_B = "b";
    localparam logic [7:0] CHAR_C = "c";
    localparam logic [7:0] CHAR_D = "d";
    localparam logic [7:0] CHAR_E = "e";
    localparam logic [7:0] CHAR_F = "f";
    localparam logic [7:0] CHAR_H = "h";
    localparam logic [7:0] CHAR_L = "l";
    localparam logic [7:0] CHAR_M = "m";
    localparam logic [7:0] CHAR_N = "n";
    localparam logic [7:0] CHAR_O = "o";
    localparam logic [7:0] CHAR_S = "s";
    localparam logic [7:0] CHAR_T = "t";
    localparam logic [7:0] CHAR_W = "w";
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [7:0] LEN_2 = 8'd2;
    localparam logic [7:0] LEN_3 = 8'd3;
    localparam logic [7:0] LEN_4 = 8'd4;

    localparam logic [4:0] BIT_DRY   = 5'd6;
    localparam logic [4:0] BIT_SLEEP = 5'd7;
    localparam logic [4:0] BIT_H     = 5'd20;
    localparam logic [4:0] BIT_L     = 5'd21;
    localparam logic [4:0] BIT_F     = 5'd22;
    localparam logic [4:0] BIT_E     = 5'd23;

    logic [7:0] a_lc;
    logic [7:0] b_lc;
    logic [7:0] c_lc;
    logic       flag_hit;
    logic [4:0] flag_idx;
    logic [5:0] temp;

    assign emits = (command_length >= LEN_2);

    always_comb
    begin
        a_lc     = first_char | CASE_BIT;
        b_lc     = second_char | CASE_BIT;
        c_lc     = third_char | CASE_BIT;
        flag_hit = 1'b0;
        flag_idx = BIT_DRY;
        temp     = 6'(second_char[1:0]) * 6'd10 + 6'(third_char[3:0]);
        op       = '0;

        if (command_length == LEN_2)
        begin
            if (a_lc == CHAR_M)
            begin
                if (second_char >= CHAR_0 && second_char <= CHAR_4)
                begin
                    op.mask[2:0]  = 3'b111;
                    op.value[2:0] = second_char[2:0];
                end
            end
            else if (a_lc == CHAR_O)
            begin
                if (b_lc == CHAR_N || second_char == CHAR_1)
                begin
                    op.mask[3]  = 1'b1;
                    op.value[3] = 1'b1;
                end
                else if (b_lc == CHAR_F || second_char == CHAR_0)
                begin
                    op.mask[3] = 1'b1;
                end
            end
            else if (a_lc == CHAR_W)
            begin
                if (second_char >= CHAR_0 && second_char <= CHAR_3)
                begin
                    op.mask[5:4]  = 2'b11;
                    op.value[5:4] = second_char[1:0];
                end
            end
            else if (a_lc == CHAR_C)
            begin
                if (second_char >= CHAR_0 && second_char <= CHAR_2)
                begin
                    op.mask[25:24]  = 2'b11;
                    op.value[25:24] = second_char[1:0];
                end
            end
            else if (a_lc == CHAR_D)
            begin
                flag_hit = 1'b1;
                flag_idx = BIT_DRY;
            end
            else if (a_lc == CHAR_S)
            begin
                flag_hit = 1'b1;
                flag_idx = BIT_SLEEP;
            end
            else if (a_lc == CHAR_H)
            begin
                flag_hit = 1'b1;
                flag_idx = BIT_H;
            end
            else if (a_lc == CHAR_L)
            begin
                flag_hit = 1'b1;
                flag_idx = BIT_L;
            end
            else if (a_lc == CHAR_F)
            begin
                flag_hit = 1'b1;
                flag_idx = BIT_F;
            end
            else if (a_lc == CHAR_E)
            begin
                flag_hit = 1'b1;
                flag_idx = BIT_E;
            end

            if (flag_hit && (second_char == CHAR_1 || second_char == CHAR_0))
            begin
                op.mask[flag_idx]  = 1'b1;
                op.value[flag_idx] = second_char[0];
            end
        end
        else if (command_length == LEN_3)
        begin
            if (a_lc == CHAR_O && b_lc == CHAR_F && c_lc == CHAR_F)
            begin
                op.mask[3] = 1'b1;
            end
            else if (a_lc == CHAR_T)
            begin
                // Temperature is stored as degrees above sixteen.
                if (second_char >= CHAR_1 && second_char <= CHAR_3 &&
                    third_char >= CHAR_0 && third_char <= CHAR_9 &&
                    temp >= 6'd16 && temp <= 6'd30)
                begin
                    op.mask[11:8]  = 4'hF;
                    op.value[11:8] = 4'(temp - 6'd16);
                end
            end
        end
        else if (command_length == LEN_4)
        begin
            if (a_lc == CHAR_B)
            begin
                op.mask[19:12] = 8'hFF;
                op.value[13]   = (second_char == CHAR_1);
                op.value[14]   = (second_char == CHAR_2);
                op.value[12]   = (fourth_char == CHAR_5);
                if (third_char >= CHAR_0 && third_char <= CHAR_9)
                begin
                    op.value[19:16] = third_char[3:0];
                end
                op.value[15] = !(second_char == CHAR_0 && third_char == CHAR_0 &&
                                 fourth_char == CHAR_0);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/acfu_queue.sv
// ============================================================================
// Air-conditioner command frame updater: operation queue
// A short first-in first-out buffer of decoded operations that lets the
// decoder and the frame register stall independently.
// ============================================================================
`default_nettype none

module acfu_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  acfu_pkg::acfu_op_t      push_op,
    output logic                    full,
    output logic                    q_valid,
    input  wire logic               pop,
    output acfu_pkg::acfu_op_t      q_op
);
    import acfu_pkg::*;

    acfu_op_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/acfu_back.sv
// ============================================================================
// Air-conditioner command frame updater: frame register and output stage
// Applies queued operations to the frame and holds each updated frame in
// an output register until the receiver takes it.
// ============================================================================
`default_nettype none

module acfu_back
#(
    parameter int FRAME_BITS = 35
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  acfu_pkg::acfu_op_t                 q_op,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [acfu_pkg::OUT_BITS-1:0]      out_frame
);
    import acfu_pkg::*;

    localparam logic [FRAME_BITS-1:0] RESET_VALUE = FRAME_BITS'(FRAME_RESET);

    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic [FRAME_BITS-1:0] mask_ext;
    logic [FRAME_BITS-1:0] value_ext;
    logic [OUT_BITS-1:0]   frame_view;
    logic [OUT_BITS-1:0]   out_frame_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // The output register is free when empty or being emptied this cycle.
    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign mask_ext  = FRAME_BITS'(q_op.mask);
    assign value_ext = FRAME_BITS'(q_op.value);

    always_comb
    begin
        frame_next     = pop ? ((frame_reg & ~mask_ext) | (value_ext & mask_ext)) : frame_reg;
        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    // The result shows the low 35 bits of the frame, zero-filled if narrower.
    for (genvar i = 0; i < OUT_BITS; i++)
    begin : g_view
        if (i < FRAME_BITS)
        begin : g_bit
            assign frame_view[i] = frame_next[i];
        end
        else
        begin : g_zero
            assign frame_view[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= RESET_VALUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_frame_reg <= frame_view;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_frame = out_frame_reg;

endmodule

`default_nettype wire

FILE: rtl/core/aircon_command_frame_updater_top.sv
// ============================================================================
// Air-conditioner command frame updater
// Keeps a remote-control frame and emits it after each ASCII command.
// ============================================================================
// Usage:
// The input channel carries one command per transaction: four command bytes
// and the command length. A command of length two to four updates the frame
// and yields one output transaction carrying the whole frame; an unknown or
// malformed command, or a length above four, re-sends the frame unchanged.
// A length below two is accepted and dropped without any output.
// One command is accepted per cycle while the queue has room. The decoder
// writes into a four-entry queue; the frame register takes one entry per
// cycle while the output register is free and loads the output register,
// so each result is registered in the queue, then in the output register.
// When the receiver stalls, the output register holds its frame and the
// queue fills; only a full queue drops s_axis_tready and blocks commands.
// Reset clears the queue and the output and restores the default frame
// (bits 9, 11, 28, 30 and 33 set).
// ============================================================================
`default_nettype none

module aircon_command_frame_updater_top
#(
    parameter int FRAME_BITS = 35
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // first_char, second_char, third_char, fourth_char, command_length
    input  wire logic [acfu_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // ir_frame, then zero padding
    output logic [acfu_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata
);
    import acfu_pkg::*;

    acfu_op_t            dec_op;
    acfu_op_t            q_op;
    logic                dec_emits;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic                push;
    logic [OUT_BITS-1:0] ir_frame;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full && dec_emits;

    acfu_front u_front
    (
        .first_char     (s_axis_tdata[7:0]),
        .second_char    (s_axis_tdata[15:8]),
        .third_char     (s_axis_tdata[23:16]),
        .fourth_char    (s_axis_tdata[31:24]),
        .command_length (s_axis_tdata[39:32]),
        .op             (dec_op),
        .emits          (dec_emits)
    );

    acfu_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (dec_op),
        .full    (q_full),
        .q_valid (q_valid),
        .pop     (q_pop),
        .q_op    (q_op)
    );

    acfu_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_frame (ir_frame)
    );

    assign m_axis_tdata = OUT_DATA_BITS'(ir_frame);

endmodule

`default_nettype wire
